>>> hdl/bba_pkg.sv
// Shared types and constants of the buddy block allocator.
package bba_pkg;

    // Default number of list cells
    localparam int MaxBlocksDefault = 32;
    // Order of the single free block after reset
    localparam logic [4:0] ResetOrder = 5'd10;
    // Width of a cell position in a command (covers up to 128 cells)
    localparam int PosW = 7;

    localparam int OwnerW = 16;
    localparam int OrderW = 5;
    localparam int SizeW  = 31;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_SPLIT,
        CMD_TAG,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [PosW-1:0]    pos;
        logic [OrderW-1:0]  order;
        logic [OwnerW-1:0]  owner;
    } cell_cmd_t;

endpackage

>>> hdl/bba_cell.sv
// One list cell: holds owner and order of one block, shifts from its left neighbor.
module bba_cell #(
    parameter int INDEX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bba_pkg::cell_cmd_t         cmd,
    input  logic [bba_pkg::OwnerW-1:0] left_owner,
    input  logic [bba_pkg::OrderW-1:0] left_order,
    output logic [bba_pkg::OwnerW-1:0] owner,
    output logic [bba_pkg::OrderW-1:0] order
);

    localparam logic [bba_pkg::PosW-1:0] MyPos = bba_pkg::PosW'(INDEX);

    logic [bba_pkg::OwnerW-1:0] owner_reg;
    logic [bba_pkg::OwnerW-1:0] owner_next;
    logic [bba_pkg::OrderW-1:0] order_reg;
    logic [bba_pkg::OrderW-1:0] order_next;
    logic [bba_pkg::PosW-1:0]   buddy_pos;

    assign buddy_pos = cmd.pos + bba_pkg::PosW'(1);

    // Decode the broadcast command against this cell's position
    always_comb
    begin
        owner_next = owner_reg;
        order_next = order_reg;
        unique case (cmd.kind)
            bba_pkg::CMD_SPLIT:
            begin
                if (MyPos == cmd.pos)
                begin
                    order_next = cmd.order;
                end
                else if (MyPos == buddy_pos)
                begin
                    owner_next = '0;
                    order_next = cmd.order;
                end
                else if (MyPos > buddy_pos)
                begin
                    owner_next = left_owner;
                    order_next = left_order;
                end
            end
            bba_pkg::CMD_TAG:
            begin
                if (MyPos == cmd.pos)
                begin
                    owner_next = cmd.owner;
                end
            end
            bba_pkg::CMD_CLEAR:
            begin
                owner_next = '0;
                order_next = (INDEX == 0) ? cmd.order : '0;
            end
            default:
            begin
                owner_next = owner_reg;
            end
        endcase
    end

    // Hold cell contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg <= '0;
            order_reg <= (INDEX == 0) ? bba_pkg::ResetOrder : '0;
        end
        else
        begin
            owner_reg <= owner_next;
            order_reg <= order_next;
        end
    end

    assign owner = owner_reg;
    assign order = order_reg;

endmodule

>>> hdl/buddy_block_allocator_top.sv
// Top level of the buddy block allocator: control sequencer and chain of list cells.
//
// Usage:
//   s_* channel takes one item per beat. s_tuser[0] is the op (0 allocate,
//   1 query); s_tdata holds owner_id and request_size.
//   m_* channel returns one beat per block for a query, in address order,
//   with m_tlast on the final block. Allocate gives no beats.
//   cfg_* writes total_order; it is always ready and rebuilds the list as a
//   single free block of that order in the cycle after the write.
// Timing:
//   Allocate goes from idle through the scan, which checks one cell per cycle,
//   to the split state, where each split shifts the chain by one cell, and
//   ends with the tag of the found block. A query starts from idle, then gives
//   one beat per cycle while the receiver is ready. One item is worked on at a
//   time; s_tready is high only between items.
// Reset:
//   The list holds one free block of order 10 and no beat is pending.
// Stall:
//   A beat waits in the output register; the query walk pauses until taken.
module buddy_block_allocator_top #(
    parameter int MAX_BLOCKS = bba_pkg::MaxBlocksDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] owner_id, [46:16] request_size, [47] zero
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [5:0] block_count, [10:6] block_index,
                                   // [26:11] owner, [31:27] block_order
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    localparam int IdxW = $clog2(MAX_BLOCKS);
    localparam int CntW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPLIT,
        ST_QUERY
    } state_t;

    state_t                       state_reg;
    logic [CntW-1:0]              idx_reg;
    logic [CntW-1:0]              total_reg;
    logic [bba_pkg::SizeW-1:0]    sm1_reg;
    logic [bba_pkg::OwnerW-1:0]   owner_id_reg;
    logic [bba_pkg::OrderW-1:0]   cur_ord_reg;
    logic                         out_valid_reg;
    logic [31:0]                  out_data_reg;
    logic                         out_last_reg;

    logic [bba_pkg::OwnerW-1:0]   cell_owner [MAX_BLOCKS];
    logic [bba_pkg::OrderW-1:0]   cell_order [MAX_BLOCKS];
    bba_pkg::cell_cmd_t           cmd;

    logic [bba_pkg::OwnerW-1:0]   rd_owner;
    logic [bba_pkg::OrderW-1:0]   rd_order;
    logic [bba_pkg::SizeW-1:0]    in_size;
    logic                         fit_full;
    logic                         half_fit;
    logic                         can_split;
    logic                         load_beat;
    logic                         is_last;

    // Chain of cells
    for (genvar k = 0; k < MAX_BLOCKS; k++)
    begin : g_cell
        logic [bba_pkg::OwnerW-1:0] left_owner;
        logic [bba_pkg::OrderW-1:0] left_order;
        if (k == 0)
        begin : g_first
            assign left_owner = '0;
            assign left_order = '0;
        end
        else
        begin : g_rest
            assign left_owner = cell_owner[k-1];
            assign left_order = cell_order[k-1];
        end
        bba_cell #(
            .INDEX (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_owner (left_owner),
            .left_order (left_order),
            .owner      (cell_owner[k]),
            .order      (cell_order[k])
        );
    end

    // Read the cell under the walk pointer
    assign rd_owner = cell_owner[idx_reg[IdxW-1:0]];
    assign rd_order = cell_order[idx_reg[IdxW-1:0]];

    // Fit tests against request - 1
    assign in_size   = s_tdata[46:16];
    assign fit_full  = ((sm1_reg >> rd_order) == '0);
    assign half_fit  = (cur_ord_reg != '0)
                    && ((sm1_reg >> (cur_ord_reg - bba_pkg::OrderW'(1))) == '0);
    assign can_split = half_fit && (total_reg < CntMax);

    assign load_beat = (state_reg == ST_QUERY) && (!out_valid_reg || m_tready);
    assign is_last   = (idx_reg == total_reg - CntW'(1));

    // Build the cell command
    always_comb
    begin
        cmd       = '0;
        cmd.kind  = bba_pkg::CMD_NOP;
        if (cfg_valid)
        begin
            cmd.kind  = bba_pkg::CMD_CLEAR;
            cmd.order = cfg_data;
        end
        else if (state_reg == ST_SPLIT)
        begin
            cmd.pos = bba_pkg::PosW'(idx_reg);
            if (can_split)
            begin
                cmd.kind  = bba_pkg::CMD_SPLIT;
                cmd.order = cur_ord_reg - bba_pkg::OrderW'(1);
            end
            else
            begin
                cmd.kind  = bba_pkg::CMD_TAG;
                cmd.owner = owner_id_reg;
            end
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            total_reg     <= CntW'(1);
            sm1_reg       <= '0;
            owner_id_reg  <= '0;
            cur_ord_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (m_tready && !load_beat)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        idx_reg      <= '0;
                        owner_id_reg <= s_tdata[15:0];
                        sm1_reg      <= (in_size == '0) ? '0
                                                        : in_size - bba_pkg::SizeW'(1);
                        state_reg    <= s_tuser[0] ? ST_QUERY : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg >= total_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if ((rd_owner == '0) && fit_full)
                    begin
                        cur_ord_reg <= rd_order;
                        state_reg   <= ST_SPLIT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CntW'(1);
                    end
                end
                ST_SPLIT:
                begin
                    if (can_split)
                    begin
                        cur_ord_reg <= cur_ord_reg - bba_pkg::OrderW'(1);
                        if (!cfg_valid)
                        begin
                            total_reg <= total_reg + CntW'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_QUERY:
                begin
                    if (load_beat)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {rd_order, rd_owner, 5'(idx_reg), 6'(total_reg)};
                        out_last_reg  <= is_last;
                        idx_reg       <= idx_reg + CntW'(1);
                        if (is_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // Rebuild the list on a register write
            if (cfg_valid)
            begin
                total_reg <= CntW'(1);
            end
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

endmodule

>>> hdl/bba_checker.sv
// Port-level checks of the buddy block allocator, bound to the top level.
module bba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled beat changed");

    // Take one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // Allocate produces no beat
    a_alloc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] |=> !$rose(m_tvalid))
        else $error("beat after allocate");

    // Advance block index by one within a query run
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast
        |=> m_tvalid && (m_tdata[10:6] == $past(m_tdata[10:6]) + 5'd1))
        else $error("block index skipped");

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
